/* hdl/glu_pkg.sv */
// ----------------------------------------------------------------------------
// glu_pkg
// Shared constants and controller/datapath interface types for the gcd/lcm unit.
// ----------------------------------------------------------------------------
package glu_pkg;

    localparam int GLU_OPERAND_BITS = 31;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture operands of a new request
        logic gcd_step;   // one binary gcd reduction step
        logic scale;      // restore common power of two, start divide
        logic div_step;   // one restoring divide step
        logic mul_step;   // one shift-add multiply step
        logic load_out;   // move finished result into output register
    } glu_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic err;        // an operand was zero
        logic gcd_done;   // one gcd operand reached zero
        logic last_step;  // step counter at its final count
    } glu_status_t;

endpackage

/* hdl/glu_ctrl.sv */
// ----------------------------------------------------------------------------
// glu_ctrl
// Sequencer for the gcd/lcm unit: handshakes and phase control.
// ----------------------------------------------------------------------------
module glu_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  glu_pkg::glu_status_t status,
    output glu_pkg::glu_cmd_t    cmd
);
    import glu_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_GCD   = 6'b000010,
        ST_SCALE = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_MUL   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (status.err) begin
                    state_next = ST_DONE;
                end else if (status.gcd_done) begin
                    state_next = ST_SCALE;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.last_step) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (status.last_step) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait until the output register is free or being drained
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

/* hdl/glu_datapath.sv */
// ----------------------------------------------------------------------------
// glu_datapath
// Binary gcd, restoring divide and shift-add multiply over shared registers.
// ----------------------------------------------------------------------------
module glu_datapath #(
    parameter int OPERAND_BITS = glu_pkg::GLU_OPERAND_BITS
) (
    input  logic                        aclk,
    input  logic [OPERAND_BITS-1:0]     s_first_value,
    input  logic [OPERAND_BITS-1:0]     s_second_value,
    input  glu_pkg::glu_cmd_t           cmd,
    output glu_pkg::glu_status_t        status,
    output logic [OPERAND_BITS-1:0]     m_divisor,
    output logic [2*OPERAND_BITS-1:0]   m_multiple,
    output logic                        m_error
);
    import glu_pkg::*;

    localparam int N     = OPERAND_BITS;
    localparam int CNT_W = $clog2(OPERAND_BITS);

    logic [N-1:0]     a_reg, b_reg;
    logic [N-1:0]     u_reg, v_reg;
    logic [CNT_W-1:0] k_reg;
    logic [N-1:0]     g_reg;
    logic [N-1:0]     rem_reg, quo_reg;
    logic [2*N-1:0]   prod_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             err_reg;
    logic [N-1:0]     div_reg;
    logic [2*N-1:0]   mult_reg;
    logic             merr_reg;

    logic [N:0]       uv_diff;
    logic [N-1:0]     vu_diff;
    logic [N:0]       div_shift, div_trial;
    logic [N-1:0]     rem_next, quo_next;
    logic [N:0]       mul_sum;
    logic [2*N-1:0]   prod_next;
    logic             last_step;

    // gcd subtract in both directions, borrow picks the larger operand
    assign uv_diff = {1'b0, u_reg} - {1'b0, v_reg};
    assign vu_diff = v_reg - u_reg;

    // restoring divide a / g
    assign div_shift = {rem_reg, quo_reg[N-1]};
    assign div_trial = div_shift - {1'b0, g_reg};
    assign rem_next  = div_trial[N] ? div_shift[N-1:0] : div_trial[N-1:0];
    assign quo_next  = {quo_reg[N-2:0], ~div_trial[N]};

    // shift-add multiply quotient * b
    assign mul_sum   = {1'b0, prod_reg[2*N-1:N]} + (prod_reg[0] ? {1'b0, b_reg} : '0);
    assign prod_next = {mul_sum, prod_reg[N-1:1]};

    assign last_step = (cnt_reg == CNT_W'(OPERAND_BITS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg   <= s_first_value;
            b_reg   <= s_second_value;
            u_reg   <= s_first_value;
            v_reg   <= s_second_value;
            k_reg   <= '0;
            err_reg <= (s_first_value == '0) || (s_second_value == '0);
        end
        if (cmd.gcd_step) begin
            if (!u_reg[0] && !v_reg[0]) begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end else if (!u_reg[0]) begin
                u_reg <= u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_reg <= v_reg >> 1;
            end else if (!uv_diff[N]) begin
                u_reg <= uv_diff[N-1:0];
            end else begin
                v_reg <= vu_diff;
            end
        end
        if (cmd.scale) begin
            g_reg   <= (u_reg | v_reg) << k_reg;
            rem_reg <= '0;
            quo_reg <= a_reg;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (last_step) begin
                prod_reg <= {{N{1'b0}}, quo_next};
                cnt_reg  <= '0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (cmd.mul_step) begin
            prod_reg <= prod_next;
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd.load_out) begin
            div_reg  <= err_reg ? '0 : g_reg;
            mult_reg <= err_reg ? '0 : prod_reg;
            merr_reg <= err_reg;
        end
    end

    assign status.err       = err_reg;
    assign status.gcd_done  = (u_reg == '0) || (v_reg == '0);
    assign status.last_step = last_step;

    assign m_divisor  = div_reg;
    assign m_multiple = mult_reg;
    assign m_error    = merr_reg;

endmodule

/* hdl/gcd_lcm_unit.sv */
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Greatest common divisor and least common multiple of two unsigned operands.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  request  | s_valid s_ready s_first_value           | in
//           | s_second_value                          |
//  result   | m_valid m_ready m_divisor m_multiple    | out
//           | m_error                                 |
//
//  one request at a time; binary gcd steps until one operand reaches zero, then
//  OPERAND_BITS divide steps and OPERAND_BITS multiply steps in a shared
//  datapath. zero operands skip from the gcd phase straight to the result. a
//  finished result waits in the output register, and the next request is
//  accepted while it waits. aresetn is synchronous and clears only the
//  sequencer and the output valid.
// ----------------------------------------------------------------------------
module gcd_lcm_unit #(
    parameter int OPERAND_BITS = glu_pkg::GLU_OPERAND_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OPERAND_BITS-1:0]   s_first_value,
    input  logic [OPERAND_BITS-1:0]   s_second_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [OPERAND_BITS-1:0]   m_divisor,
    output logic [2*OPERAND_BITS-1:0] m_multiple,
    output logic                      m_error
);
    import glu_pkg::*;

    glu_cmd_t    cmd;
    glu_status_t status;

    glu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    glu_datapath #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .s_first_value  (s_first_value),
        .s_second_value (s_second_value),
        .cmd            (cmd),
        .status         (status),
        .m_divisor      (m_divisor),
        .m_multiple     (m_multiple),
        .m_error        (m_error)
    );

endmodule

/* hdl/glu_checker.sv */
// ----------------------------------------------------------------------------
// glu_checker
// Port-level checks for the gcd/lcm unit, bound to the top level.
// ----------------------------------------------------------------------------
module glu_checker #(
    parameter int OPERAND_BITS = glu_pkg::GLU_OPERAND_BITS
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [OPERAND_BITS-1:0]   m_divisor,
    input logic [2*OPERAND_BITS-1:0] m_multiple,
    input logic                      m_error
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_divisor)
            && $stable(m_multiple) && $stable(m_error))
        else $error("stalled result changed");

    // one request in flight: ready drops after an accept
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request accepted while busy");

    // error results carry zeros
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_divisor == '0 && m_multiple == '0)
        else $error("error result with nonzero fields");

    // a good result has a nonzero divisor and multiple
    a_ok_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_error |-> m_divisor != '0 && m_multiple != '0)
        else $error("good result with zero field");

endmodule

bind gcd_lcm_unit glu_checker #(.OPERAND_BITS(OPERAND_BITS)) u_glu_checker (.*);
